FILE: hdl/krt_pkg.sv
package krt_pkg;

    // Action codes carried on the action field.
    localparam logic [2:0] ACT_ADD    = 3'd0;
    localparam logic [2:0] ACT_SEARCH = 3'd1;
    localparam logic [2:0] ACT_UPDATE = 3'd2;
    localparam logic [2:0] ACT_DELETE = 3'd3;
    localparam logic [2:0] ACT_READ   = 3'd4;

    // Status codes returned with every result word.
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;
    localparam logic [1:0] ST_BEYOND    = 2'd3;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_SCAN,
        S_SHIFT,
        S_RESP
    } krt_state_t;

    // One stored record.
    typedef struct packed {
        logic [31:0]        key;
        logic signed [31:0] quantity;
        logic [31:0]        price_cents;
    } record_t;

    // One command word as taken from the input channel.
    typedef struct packed {
        logic [2:0]         action;
        logic [31:0]        key;
        logic signed [31:0] quantity;
        logic [31:0]        price_cents;
        logic [5:0]         slot_index;
    } cmd_t;

    // One result word handed to the output register.
    typedef struct packed {
        logic [1:0]         status;
        logic [31:0]        key;
        logic signed [31:0] quantity;
        logic [31:0]        price_cents;
        logic [5:0]         slot;
        logic [6:0]         record_count;
    } rsp_t;

endpackage

FILE: hdl/krt_mem.sv
module krt_mem
    import krt_pkg::*;
#(
    parameter int DEPTH = 64,
    parameter int AW    = 6
)
(
    input  logic            clk,
    input  logic            we,
    input  logic [AW-1:0]   waddr,
    input  record_t         wdata,
    input  logic            re,
    input  logic [AW-1:0]   raddr,
    output record_t         rdata
);

    record_t mem [DEPTH];
    record_t rdata_reg;

    // Single write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Single read port with registered data.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: hdl/krt_ctrl.sv
module krt_ctrl
    import krt_pkg::*;
#(
    parameter int DEPTH = 64,
    parameter int AW    = 6,
    parameter int CW    = 7
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    input  cmd_t            cmd,
    output logic            rsp_valid,
    input  logic            rsp_take,
    output rsp_t            rsp,
    output logic            mem_we,
    output logic [AW-1:0]   mem_waddr,
    output record_t         mem_wdata,
    output logic            mem_re,
    output logic [AW-1:0]   mem_raddr,
    input  record_t         mem_rdata
);

    krt_state_t     state_reg, state_next;
    logic [CW-1:0]  count_reg, count_next;
    cmd_t           cmd_reg, cmd_next;
    logic [AW-1:0]  cur_reg, cur_next;
    rsp_t           res_reg, res_next;

    logic [CW:0]    cur_ext;
    logic [CW:0]    cur_inc;
    logic [CW:0]    cur_inc2;
    logic [CW:0]    cnt_ext;
    logic           idx_beyond;
    logic           table_full;

    assign cur_ext    = (CW+1)'(cur_reg);
    assign cur_inc    = cur_ext + (CW+1)'(1);
    assign cur_inc2   = cur_inc + (CW+1)'(1);
    assign cnt_ext    = (CW+1)'(count_reg);
    assign idx_beyond = (CW+6)'(cmd.slot_index) >= (CW+6)'(count_reg);
    assign table_full = count_reg >= CW'(DEPTH);

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    // Command, scan position and result registers.
    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        cur_reg <= cur_next;
        res_reg <= res_next;
    end

    // Sequencer: next state, memory accesses and result.
    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        cmd_next   = cmd_reg;
        cur_next   = cur_reg;
        res_next   = res_reg;
        mem_we     = 1'b0;
        mem_waddr  = cur_reg;
        mem_wdata  = mem_rdata;
        mem_re     = 1'b0;
        mem_raddr  = cur_reg;
        in_stall   = (state_reg != S_IDLE);
        rsp_valid  = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_next   = cmd;
                    res_next   = '0;
                    state_next = S_RESP;
                    case (cmd.action)
                        ACT_ADD:
                        begin
                            if (table_full)
                            begin
                                res_next.status = ST_FULL;
                            end
                            else
                            begin
                                mem_we                = 1'b1;
                                mem_waddr             = AW'(count_reg);
                                mem_wdata.key         = cmd.key;
                                mem_wdata.quantity    = cmd.quantity;
                                mem_wdata.price_cents = cmd.price_cents;
                                res_next.status       = ST_OK;
                                res_next.key          = cmd.key;
                                res_next.quantity     = cmd.quantity;
                                res_next.price_cents  = cmd.price_cents;
                                res_next.slot         = 6'(count_reg);
                                count_next            = count_reg + CW'(1);
                            end
                        end
                        ACT_SEARCH, ACT_UPDATE, ACT_DELETE:
                        begin
                            if (count_reg == '0)
                            begin
                                res_next.status = ST_NOT_FOUND;
                            end
                            else
                            begin
                                mem_re     = 1'b1;
                                mem_raddr  = '0;
                                cur_next   = '0;
                                state_next = S_SCAN;
                            end
                        end
                        ACT_READ:
                        begin
                            if (idx_beyond)
                            begin
                                res_next.status = ST_BEYOND;
                            end
                            else
                            begin
                                mem_re     = 1'b1;
                                mem_raddr  = AW'(cmd.slot_index);
                                cur_next   = AW'(cmd.slot_index);
                                state_next = S_READ;
                            end
                        end
                        default:
                        begin
                            res_next.status = ST_OK;
                        end
                    endcase
                end
            end

            S_READ:
            begin
                res_next.status      = ST_OK;
                res_next.key         = mem_rdata.key;
                res_next.quantity    = mem_rdata.quantity;
                res_next.price_cents = mem_rdata.price_cents;
                res_next.slot        = 6'(cur_reg);
                state_next           = S_RESP;
            end

            S_SCAN:
            begin
                if (mem_rdata.key == cmd_reg.key)
                begin
                    // First match: report it, then act on it.
                    res_next.status      = ST_OK;
                    res_next.key         = mem_rdata.key;
                    res_next.quantity    = mem_rdata.quantity;
                    res_next.price_cents = mem_rdata.price_cents;
                    res_next.slot        = 6'(cur_reg);
                    state_next           = S_RESP;
                    if (cmd_reg.action == ACT_UPDATE)
                    begin
                        mem_we             = 1'b1;
                        mem_wdata.quantity = cmd_reg.quantity;
                        res_next.quantity  = cmd_reg.quantity;
                    end
                    else if (cmd_reg.action == ACT_DELETE)
                    begin
                        if (cur_inc < cnt_ext)
                        begin
                            mem_re     = 1'b1;
                            mem_raddr  = AW'(cur_inc);
                            state_next = S_SHIFT;
                        end
                        else
                        begin
                            count_next = count_reg - CW'(1);
                        end
                    end
                end
                else if (cur_inc < cnt_ext)
                begin
                    mem_re    = 1'b1;
                    mem_raddr = AW'(cur_inc);
                    cur_next  = AW'(cur_inc);
                end
                else
                begin
                    res_next        = '0;
                    res_next.status = ST_NOT_FOUND;
                    state_next      = S_RESP;
                end
            end

            S_SHIFT:
            begin
                // Move the record read last cycle down one slot.
                mem_we   = 1'b1;
                cur_next = AW'(cur_inc);
                if (cur_inc2 < cnt_ext)
                begin
                    mem_re    = 1'b1;
                    mem_raddr = AW'(cur_inc2);
                end
                else
                begin
                    count_next = count_reg - CW'(1);
                    state_next = S_RESP;
                end
            end

            S_RESP:
            begin
                rsp_valid = 1'b1;
                if (rsp_take)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // The count shown is always the count after the action.
    always_comb
    begin
        rsp              = res_reg;
        rsp.record_count = 7'(count_reg);
    end

`ifndef SYNTHESIS
    // The table never holds more records than it has slots.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("record count beyond table depth");

    // A shift step only writes inside the held records.
    a_shift_inside: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SHIFT) |-> (cur_inc < cnt_ext))
        else $error("shift outside held records");

    // A result not yet taken holds its value.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_take) |=> (rsp_valid && $stable(rsp)))
        else $error("pending result changed");

    // The count changes by at most one per cycle.
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |->
            (count_reg == $past(count_reg) + CW'(1)
             || count_reg + CW'(1) == $past(count_reg)))
        else $error("record count jumped");
`endif

endmodule

FILE: hdl/keyed_record_table.sv
// Keyed record table: up to TABLE_DEPTH records of identifier, quantity and
// price in cents, held in slot order in one record memory.
// Input channel: in_valid with in_stall carries one command word (action,
// item_key, new_quantity, new_price_cents, slot_index). A word is taken when
// in_valid is high and in_stall is low.
// Output channel: out_valid with out_stall carries exactly one result word
// per command (status, found_* fields, record_count).
// Commands are handled one at a time. The memory has one read port, so a
// scan or a delete shift moves one slot per cycle: add writes the next free
// slot, read fetches its slot, search and update scan from slot 0 to the
// match, and delete scans to the match, then shifts the rest down. Input is
// stalled while a command is in work.
// The result goes into an output register, so the next command is taken
// while the previous result still waits; if out_stall is held, the block
// finishes that next command and then waits with its result.
// Reset clears the record count and the handshakes; memory contents are not
// cleared and there is no sweep after reset.
module keyed_record_table
    import krt_pkg::*;
#(
    parameter int TABLE_DEPTH = 64
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [2:0]         action,
    input  logic [31:0]        item_key,
    input  logic signed [31:0] new_quantity,
    input  logic [31:0]        new_price_cents,
    input  logic [5:0]         slot_index,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [1:0]         status,
    output logic [31:0]        found_key,
    output logic signed [31:0] found_quantity,
    output logic [31:0]        found_price_cents,
    output logic [5:0]         found_slot,
    output logic [6:0]         record_count
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    cmd_t           cmd;
    rsp_t           rsp;
    logic           rsp_valid;
    logic           rsp_take;
    logic           mem_we;
    logic [AW-1:0]  mem_waddr;
    record_t        mem_wdata;
    logic           mem_re;
    logic [AW-1:0]  mem_raddr;
    record_t        mem_rdata;
    logic           out_valid_reg, out_valid_next;
    rsp_t           out_reg;

    // Gather the command word.
    always_comb
    begin
        cmd.action      = action;
        cmd.key         = item_key;
        cmd.quantity    = new_quantity;
        cmd.price_cents = new_price_cents;
        cmd.slot_index  = slot_index;
    end

    krt_ctrl #(
        .DEPTH (TABLE_DEPTH),
        .AW    (AW),
        .CW    (CW)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_take  (rsp_take),
        .rsp       (rsp),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_re    (mem_re),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    krt_mem #(
        .DEPTH (TABLE_DEPTH),
        .AW    (AW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // Output register: loads when empty or when its word is being taken.
    assign rsp_take = rsp_valid && (!out_valid_reg || !out_stall);

    always_comb
    begin
        if (rsp_take)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && out_stall)
        begin
            out_valid_next = 1'b1;
        end
        else
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rsp_take)
        begin
            out_reg <= rsp;
        end
    end

    assign out_valid         = out_valid_reg;
    assign status            = out_reg.status;
    assign found_key         = out_reg.key;
    assign found_quantity    = out_reg.quantity;
    assign found_price_cents = out_reg.price_cents;
    assign found_slot        = out_reg.slot;
    assign record_count      = out_reg.record_count;

endmodule

FILE: bench/keyed_record_table_tb.sv
module keyed_record_table_tb
    import krt_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH        = 64;
    localparam int RANDOM_WORDS = 1500;
    localparam int TAIL_CYCLES  = 100;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int DRILL_ROWS   = 25;

    // Action codes the block treats as no-ops.
    localparam logic [2:0] ACT_RSVD5 = 3'd5;
    localparam logic [2:0] ACT_RSVD6 = 3'd6;
    localparam logic [2:0] ACT_RSVD7 = 3'd7;
    localparam logic [2:0] RSVD_ACTS [3] = '{ACT_RSVD5, ACT_RSVD6, ACT_RSVD7};

    localparam logic [31:0]        KONES = 32'hFFFF_FFFF;
    localparam logic [31:0]        K5A   = 32'h5A5A_A5A5;
    localparam logic signed [31:0] QTOP  = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] QBOT  = 32'sh8000_0000;

    // Identifiers reused often so that lookups hit and duplicates appear.
    localparam logic [31:0] KEY_POOL [8] = '{
        32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001, 32'h8000_0000,
        32'h7FFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA, 32'h0001_0000
    };

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [2:0]         action = ACT_ADD;
    logic [31:0]        item_key = '0;
    logic signed [31:0] new_quantity = '0;
    logic [31:0]        new_price_cents = '0;
    logic [5:0]         slot_index = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [1:0]         status;
    logic [31:0]        found_key;
    logic signed [31:0] found_quantity;
    logic [31:0]        found_price_cents;
    logic [5:0]         found_slot;
    logic [6:0]         record_count;

    // Shadow copy of the table contents.
    record_t rec_tab [DEPTH];
    int      rec_count = 0;

    rsp_t awaited_results [$];
    int   error_count = 0;
    int   cycle_count = 0;
    int   in_idle_pct = 32;
    int   out_stall_pct = 84;

    // One directed word; the result is typed in only where it is obvious.
    typedef struct packed {
        logic typed;
        cmd_t cmd;
        rsp_t res;
    } drill_row_t;

    drill_row_t drill_rows [DRILL_ROWS] = '{
        '{1'b1, '{ACT_READ, 0, 0, 0, 0}, '{ST_BEYOND, 0, 0, 0, 0, 0}},
        '{1'b1, '{ACT_SEARCH, 0, 5, 7, 0}, '{ST_NOT_FOUND, 0, 0, 0, 0, 0}},
        '{1'b1, '{ACT_UPDATE, KONES, QTOP, 0, 0}, '{ST_NOT_FOUND, 0, 0, 0, 0, 0}},
        '{1'b1, '{ACT_DELETE, 32'h1234_5678, 0, 0, 0}, '{ST_NOT_FOUND, 0, 0, 0, 0, 0}},
        '{1'b1, '{ACT_ADD, KONES, QTOP, KONES, 6'h3F}, '{ST_OK, KONES, QTOP, KONES, 0, 1}},
        '{1'b1, '{ACT_ADD, 0, QBOT, 0, 0}, '{ST_OK, 0, QBOT, 0, 1, 2}},
        '{1'b1, '{ACT_ADD, KONES, -1, 100, 0}, '{ST_OK, KONES, -1, 100, 2, 3}},
        '{1'b0, '{ACT_ADD, K5A, 1234, 99, 6'h2A}, '0},
        '{1'b1, '{ACT_SEARCH, KONES, 0, 0, 0}, '{ST_OK, KONES, QTOP, KONES, 0, 4}},
        '{1'b1, '{ACT_UPDATE, KONES, 0, 0, 0}, '{ST_OK, KONES, 0, KONES, 0, 4}},
        '{1'b0, '{ACT_UPDATE, K5A, QBOT, KONES, 6'h15}, '0},
        '{1'b1, '{ACT_READ, 0, 0, 0, 2}, '{ST_OK, KONES, -1, 100, 2, 4}},
        '{1'b1, '{ACT_READ, 0, 0, 0, 4}, '{ST_BEYOND, 0, 0, 0, 0, 4}},
        '{1'b1, '{ACT_READ, KONES, -1, KONES, 63}, '{ST_BEYOND, 0, 0, 0, 0, 4}},
        '{1'b1, '{ACT_RSVD5, KONES, -1, KONES, 63}, '{ST_OK, 0, 0, 0, 0, 4}},
        '{1'b1, '{ACT_RSVD6, KONES, -1, KONES, 63}, '{ST_OK, 0, 0, 0, 0, 4}},
        '{1'b1, '{ACT_RSVD7, KONES, -1, KONES, 63}, '{ST_OK, 0, 0, 0, 0, 4}},
        '{1'b1, '{ACT_DELETE, 0, 0, 0, 0}, '{ST_OK, 0, QBOT, 0, 1, 3}},
        '{1'b1, '{ACT_READ, 0, 0, 0, 1}, '{ST_OK, KONES, -1, 100, 1, 3}},
        '{1'b1, '{ACT_DELETE, KONES, 0, 0, 0}, '{ST_OK, KONES, 0, KONES, 0, 2}},
        '{1'b0, '{ACT_SEARCH, K5A, 0, 0, 0}, '0},
        '{1'b1, '{ACT_DELETE, KONES, 0, 0, 0}, '{ST_OK, KONES, -1, 100, 0, 1}},
        '{1'b0, '{ACT_DELETE, K5A, 0, 0, 0}, '0},
        '{1'b1, '{ACT_SEARCH, KONES, 0, 0, 0}, '{ST_NOT_FOUND, 0, 0, 0, 0, 0}},
        '{1'b1, '{ACT_READ, 0, 0, 0, 0}, '{ST_BEYOND, 0, 0, 0, 0, 0}}
    };

    keyed_record_table #(
        .TABLE_DEPTH(DEPTH)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .action(action),
        .item_key(item_key),
        .new_quantity(new_quantity),
        .new_price_cents(new_price_cents),
        .slot_index(slot_index),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .status(status),
        .found_key(found_key),
        .found_quantity(found_quantity),
        .found_price_cents(found_price_cents),
        .found_slot(found_slot),
        .record_count(record_count)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // The fields of a held record as the block reports them.
    function automatic rsp_t record_report(int s);
        rsp_t r;
        r = '0;
        r.status = ST_OK;
        r.key = rec_tab[s].key;
        r.quantity = rec_tab[s].quantity;
        r.price_cents = rec_tab[s].price_cents;
        r.slot = 6'(s);
        return r;
    endfunction

    // Carries out one command on the shadow table and returns its result word.
    function automatic rsp_t apply_command(cmd_t c);
        rsp_t r;
        int   hit;
        r = '0;
        hit = -1;
        // Scan downward so the lowest matching slot wins.
        for (int s = rec_count - 1; s >= 0; s--)
        begin
            if (rec_tab[s].key == c.key)
                hit = s;
        end
        case (c.action)
            ACT_ADD:
            begin
                if (rec_count >= DEPTH)
                    r.status = ST_FULL;
                else
                begin
                    rec_tab[rec_count] = '{c.key, c.quantity, c.price_cents};
                    rec_count++;
                    r = record_report(rec_count - 1);
                end
            end
            ACT_SEARCH:
            begin
                if (hit < 0)
                    r.status = ST_NOT_FOUND;
                else
                    r = record_report(hit);
            end
            ACT_UPDATE:
            begin
                if (hit < 0)
                    r.status = ST_NOT_FOUND;
                else
                begin
                    rec_tab[hit].quantity = c.quantity;
                    r = record_report(hit);
                end
            end
            ACT_DELETE:
            begin
                if (hit < 0)
                    r.status = ST_NOT_FOUND;
                else
                begin
                    // Report the record first, then close the gap in order.
                    r = record_report(hit);
                    for (int s = hit; s < rec_count - 1; s++)
                        rec_tab[s] = rec_tab[s + 1];
                    rec_count--;
                end
            end
            ACT_READ:
            begin
                if (int'(c.slot_index) >= rec_count)
                    r.status = ST_BEYOND;
                else
                    r = record_report(int'(c.slot_index));
            end
            default:
            begin
            end
        endcase
        r.record_count = 7'(rec_count);
        return r;
    endfunction

    // Presents one command word after a random gap and waits until it is taken.
    task automatic issue_word(input cmd_t c, input bit typed, input rsp_t given);
        rsp_t predicted;
        while ($urandom_range(0, 99) < in_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid        <= 1'b1;
        action          <= c.action;
        item_key        <= c.key;
        new_quantity    <= c.quantity;
        new_price_cents <= c.price_cents;
        slot_index      <= c.slot_index;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predicted = apply_command(c);
        awaited_results.push_back(typed ? given : predicted);
    endtask

    task automatic flag_mismatch(input string what);
        if (error_count < 50)
            $display("mismatch at cycle %0d: %s", cycle_count, what);
        error_count++;
    endtask

    // Receiver back-pressure.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
            out_stall <= ($urandom_range(0, 99) < out_stall_pct);
    end

    // Compare every taken result word with the oldest awaited one.
    always @(posedge clk)
    begin : result_check
        rsp_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (awaited_results.size() == 0)
                flag_mismatch("result word with nothing awaited");
            else
            begin
                want = awaited_results.pop_front();
                if (status !== want.status)
                    flag_mismatch($sformatf("status %0d, want %0d", status, want.status));
                if (found_key !== want.key)
                    flag_mismatch($sformatf("found_key %h, want %h", found_key, want.key));
                if (found_quantity !== want.quantity)
                    flag_mismatch($sformatf("found_quantity %h, want %h",
                                            found_quantity, want.quantity));
                if (found_price_cents !== want.price_cents)
                    flag_mismatch($sformatf("found_price_cents %h, want %h",
                                            found_price_cents, want.price_cents));
                if (found_slot !== want.slot)
                    flag_mismatch($sformatf("found_slot %0d, want %0d", found_slot, want.slot));
                if (record_count !== want.record_count)
                    flag_mismatch($sformatf("record_count %0d, want %0d",
                                            record_count, want.record_count));
            end
        end
    end

    // Watchdog.
    always @(posedge clk)
    begin
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
        else
            cycle_count <= cycle_count + 1;
    end

    initial
    begin : stimulus
        cmd_t word;
        int   pick;
        bit   growing;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (drill_rows[i])
            issue_word(drill_rows[i].cmd, drill_rows[i].typed, drill_rows[i].res);

        // Random traffic swings the table between empty and full so that
        // full-table adds and empty-table lookups keep recurring.
        growing = 1'b1;
        for (int n = 0; n < RANDOM_WORDS; n++)
        begin
            if (n == RANDOM_WORDS / 3)
            begin
                in_idle_pct = 84;
                out_stall_pct = 32;
            end
            else if (n == 2 * RANDOM_WORDS / 3)
            begin
                in_idle_pct = 0;
                out_stall_pct = 0;
            end

            if (growing && rec_count == DEPTH && $urandom_range(0, 3) == 0)
                growing = 1'b0;
            else if (!growing && rec_count == 0 && $urandom_range(0, 2) == 0)
                growing = 1'b1;

            // Action mix depends on whether the table is filling or draining.
            pick = $urandom_range(0, 99);
            if (pick < (growing ? 50 : 8))
                word.action = ACT_ADD;
            else if (pick < (growing ? 65 : 23))
                word.action = ACT_SEARCH;
            else if (pick < (growing ? 77 : 35))
                word.action = ACT_UPDATE;
            else if (pick < (growing ? 87 : 85))
                word.action = ACT_DELETE;
            else if (pick < 97)
                word.action = ACT_READ;
            else
                word.action = RSVD_ACTS[$urandom_range(0, 2)];

            // Mostly keys already held, then pool keys, then fresh ones.
            pick = $urandom_range(0, 99);
            if (rec_count > 0 && pick < 70)
                word.key = rec_tab[$urandom_range(0, rec_count - 1)].key;
            else if (pick < 85)
                word.key = KEY_POOL[$urandom_range(0, 7)];
            else
                word.key = $urandom;

            pick = $urandom_range(0, 99);
            if (pick < 5)
                word.quantity = QTOP;
            else if (pick < 10)
                word.quantity = QBOT;
            else
                word.quantity = $urandom;

            pick = $urandom_range(0, 99);
            if (pick < 5)
                word.price_cents = KONES;
            else if (pick < 10)
                word.price_cents = '0;
            else
                word.price_cents = $urandom;

            if (rec_count > 0 && $urandom_range(0, 99) < 70)
                word.slot_index = 6'($urandom_range(0, rec_count - 1));
            else
                word.slot_index = 6'($urandom_range(0, 63));

            issue_word(word, 1'b0, '0);
        end
        in_valid <= 1'b0;

        while (awaited_results.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
